// File: hw/rtl/rts_pkg.sv
// Shared types and constants for the timer slot bank.
// Used by the slot cell and the top level; depends on nothing.
package rts_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int TIME_W = 32;
  localparam int MODE_W = 2;
  localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COOLDOWN = 2'd2;

  localparam logic [CNT_W-1:0] IN_USE_RESET = 4'd8;

  typedef struct packed {
    logic              active;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] deadline;
  } slot_rec_t;

  typedef struct packed {
    logic shift;
    logic start;
    logic clear;
  } cell_ctl_t;

endpackage

// File: hw/rtl/rts_cell.sv
// One timer slot of the ring: holds its record, takes a start or cancel,
// shifts in its neighbor's record during a tick scan. Uses rts_pkg.
module rts_cell import rts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  slot_rec_t         start_rec,
  input  slot_rec_t         shift_in,
  input  logic [TIME_W-1:0] now,
  output slot_rec_t         rec,
  output logic              due
);

  logic [TIME_W-1:0] diff;
  logic              keep;

  // cooldown start on a running slot leaves it alone
  assign keep = (start_rec.mode == MODE_COOLDOWN) && rec.active;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (ctl.clear) begin
      rec <= '0;
    end else if (ctl.start && !keep) begin
      rec <= start_rec;
    end else if (ctl.shift) begin
      rec <= shift_in;
    end
  end

  // wrap-safe compare: now minus deadline read as signed is not negative
  assign diff = now - rec.deadline;
  assign due  = rec.active && !diff[TIME_W-1];

endmodule

// File: hw/rtl/rule_timer_slot_bank_top.sv
// Top level of the timer slot bank: ring of slot cells, scan control,
// output register. Uses rts_pkg and rts_cell.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | req_type .. now_ms
//   out     | output    | out_valid / out_stall  | fired_index, fired_duration, last_fire
//   cfg     | input     | cfg_wr_en              | cfg_wr_data (timers_in_use)
//
// Start and cancel words never stall the input. A tick with due slots rotates the
// ring of 8 cells once, one cell per cycle while the output register is not
// stalled, and no new word is taken until the rotation ends; a tick with nothing
// due leaves the ring at rest and does not stall the input. in_stall is high while the ring
// rotates. Reset clears every slot and sets timers_in_use to 8.
module rule_timer_slot_bank_top import rts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [IDX_W-1:0]  slot_sel,
  input  logic [MODE_W-1:0] arm_mode,
  input  logic [TIME_W-1:0] first_delay,
  input  logic [TIME_W-1:0] repeat_period,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  fired_index,
  output logic [TIME_W-1:0] fired_duration,
  output logic              last_fire,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  logic [CNT_W-1:0]  timers_in_use;
  logic              scanning;
  logic [STEP_W-1:0] step;
  logic [SLOTS-1:0]  mask;
  logic [SLOTS-1:0]  mask_init;
  logic [TIME_W-1:0] now_q;
  logic              accept;
  logic              advance;
  logic              step_last;
  slot_rec_t         start_rec;
  slot_rec_t         tail_in;
  slot_rec_t         rec   [SLOTS];
  slot_rec_t         shin  [SLOTS];
  cell_ctl_t         ctl   [SLOTS];
  logic [SLOTS-1:0]  due;

  assign in_stall  = scanning;
  assign accept    = in_valid && !scanning;
  assign advance   = scanning && (!out_valid || !out_stall);
  assign step_last = (step == STEP_W'(SLOTS - 1));

  always_comb begin
    start_rec.active   = 1'b1;
    start_rec.mode     = arm_mode;
    start_rec.duration = first_delay;
    start_rec.interval = (repeat_period != '0) ? repeat_period : first_delay;
    start_rec.deadline = now_ms + ((first_delay != '0) ? first_delay : repeat_period);
  end

  // head cell result goes back in at the tail: re-arm repeat, drop others
  always_comb begin
    tail_in = rec[0];
    if (mask[0]) begin
      if (rec[0].mode == MODE_REPEAT) begin
        tail_in.deadline = now_q +
          ((rec[0].interval != '0) ? rec[0].interval : rec[0].duration);
      end else begin
        tail_in.active = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign shin[i] = tail_in;
    end else begin : g_mid
      assign shin[i] = rec[i+1];
    end

    always_comb begin
      ctl[i].shift = advance;
      ctl[i].start = accept && (req_type == REQ_START) && (int'(slot_sel) == i);
      ctl[i].clear = accept && (req_type == REQ_CANCEL) && (int'(slot_sel) == i);
    end

    assign mask_init[i] = due[i] && (int'(timers_in_use) > i);

    rts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .start_rec (start_rec),
      .shift_in  (shin[i]),
      .now       (now_ms),
      .rec       (rec[i]),
      .due       (due[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timers_in_use <= IN_USE_RESET;
    end else if (cfg_wr_en) begin
      timers_in_use <= cfg_wr_data;
    end
  end

  // scan control: mask shifts with the ring so bit 0 always tracks the head
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      step     <= '0;
      mask     <= '0;
    end else if (accept && (req_type == REQ_TICK) && (mask_init != '0)) begin
      scanning <= 1'b1;
      step     <= '0;
      mask     <= mask_init;
    end else if (advance) begin
      mask <= mask >> 1;
      if (step_last) begin
        scanning <= 1'b0;
        step     <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && mask[0]) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mask[0]) begin
      fired_index    <= IDX_W'(step);
      fired_duration <= rec[0].duration;
      last_fire      <= ((mask >> 1) == '0);
    end
  end

  a_mask_empty_at_end: assert property (@(posedge clk) disable iff (rst)
    (advance && step_last) |=> (mask == '0))
    else $error("due mask not empty after full rotation");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !scanning |-> (step == '0))
    else $error("step counter nonzero while idle");

  a_fire_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && mask[0]))
    else $error("output word appeared without a due head slot");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for rule_timer_slot_bank_top: start, cancel and tick words,
// scan-count settings and output back-pressure, checked against a local slot model.
// Depends on rts_pkg and the RTL of the timer slot bank.
module tb_top import rts_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        REQ_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                MAX_GAP     = 14;
  localparam int                SETTLE      = 12;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] dur;
    logic              last;
  } fire_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        req_type;
  logic [IDX_W-1:0]  slot_sel;
  logic [MODE_W-1:0] arm_mode;
  logic [TIME_W-1:0] first_delay;
  logic [TIME_W-1:0] repeat_period;
  logic [TIME_W-1:0] now_ms;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  fired_index;
  logic [TIME_W-1:0] fired_duration;
  logic              last_fire;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;

  // local copy of the slot bank
  logic              slot_on  [SLOTS];
  logic [MODE_W-1:0] slot_md  [SLOTS];
  logic [TIME_W-1:0] slot_dur [SLOTS];
  logic [TIME_W-1:0] slot_ivl [SLOTS];
  logic [TIME_W-1:0] slot_due [SLOTS];
  logic [CNT_W-1:0]  in_use;

  fire_t             due_fires[$];
  int                err_cnt;
  logic [TIME_W-1:0] wall_ms;
  bit                tx_fast;
  bit                rx_fast;
  int                rx_hold;

  rule_timer_slot_bank_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .slot_sel       (slot_sel),
    .arm_mode       (arm_mode),
    .first_delay    (first_delay),
    .repeat_period  (repeat_period),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .fired_index    (fired_index),
    .fired_duration (fired_duration),
    .last_fire      (last_fire),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int pick_gap(input bit fast);
    return fast ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void flag_error(input string what, input logic [TIME_W-1:0] exp_v,
                                     input logic [TIME_W-1:0] act_v);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t mismatch %s: expected %0h got %0h", $time, what, exp_v, act_v);
    end
  endfunction

  function automatic void reset_slots();
    in_use = IN_USE_RESET;
    for (int k = 0; k < SLOTS; k++) begin
      slot_on[k]  = 1'b0;
      slot_md[k]  = MODE_ONESHOT;
      slot_dur[k] = '0;
      slot_ivl[k] = '0;
      slot_due[k] = '0;
    end
  endfunction

  // Update the slot copy for one accepted word and queue the fires it causes.
  function automatic void apply_request(input logic [1:0] rq, input logic [IDX_W-1:0] ix,
                                        input logic [MODE_W-1:0] md,
                                        input logic [TIME_W-1:0] d,
                                        input logic [TIME_W-1:0] iv,
                                        input logic [TIME_W-1:0] nw);
    int lim;
    int n;
    logic [TIME_W-1:0] diff;
    fire_t f;
    n = 0;
    unique case (rq)
      REQ_START: begin
        // cooldown leaves a running slot untouched
        if (!(md == MODE_COOLDOWN && slot_on[ix])) begin
          slot_on[ix]  = 1'b1;
          slot_md[ix]  = md;
          slot_dur[ix] = d;
          slot_ivl[ix] = (iv != '0) ? iv : d;
          slot_due[ix] = nw + ((d != '0) ? d : iv);
        end
      end
      REQ_CANCEL: begin
        slot_on[ix]  = 1'b0;
        slot_md[ix]  = MODE_ONESHOT;
        slot_dur[ix] = '0;
        slot_ivl[ix] = '0;
        slot_due[ix] = '0;
      end
      REQ_TICK: begin
        lim = (int'(in_use) > SLOTS) ? SLOTS : int'(in_use);
        for (int k = 0; k < lim; k++) begin
          // due when now minus deadline is non-negative as a signed value
          diff = nw - slot_due[k];
          if (slot_on[k] && !diff[TIME_W-1]) begin
            if (slot_md[k] == MODE_REPEAT) begin
              slot_due[k] = nw + ((slot_ivl[k] != '0) ? slot_ivl[k] : slot_dur[k]);
            end else begin
              slot_on[k] = 1'b0;
            end
            f.idx  = IDX_W'(k);
            f.dur  = slot_dur[k];
            f.last = 1'b0;
            due_fires.push_back(f);
            n++;
          end
        end
        if (n > 0) due_fires[due_fires.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Offer one word after a random gap; returns at the edge that accepts it,
  // with in_valid still high.
  task automatic offer_request(input logic [1:0] rq, input logic [IDX_W-1:0] ix,
                               input logic [MODE_W-1:0] md, input logic [TIME_W-1:0] d,
                               input logic [TIME_W-1:0] iv, input logic [TIME_W-1:0] nw);
    int gap;
    gap = pick_gap(tx_fast);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq;
    slot_sel      <= ix;
    arm_mode      <= md;
    first_delay   <= d;
    repeat_period <= iv;
    now_ms        <= nw;
    do @(posedge clk); while (in_stall);
    apply_request(rq, ix, md, d, iv, nw);
  endtask

  task automatic tick_at(input logic [TIME_W-1:0] nw);
    offer_request(REQ_TICK, IDX_W'($urandom), MODE_W'($urandom), $urandom, $urandom, nw);
  endtask

  // Drop valid and wait until every fire has come out and the ring is at rest.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_fires.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_in_use(input logic [CNT_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    in_use = val;
  endtask

  function automatic logic [TIME_W-1:0] pick_span();
    unique case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4,
      5, 6:    return $urandom_range(1, 12);
      7:       return $urandom;
      8:       return 32'h7FFF_FFF0 + $urandom_range(0, 31);
      default: return $urandom_range(13, 60);
    endcase
  endfunction

  task automatic random_request();
    logic [1:0]        rq;
    logic [IDX_W-1:0]  ix;
    logic [MODE_W-1:0] md;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] nw;
    int pick;
    pick = $urandom_range(0, 99);
    ix = IDX_W'($urandom);
    md = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
    d  = pick_span();
    iv = pick_span();
    nw = wall_ms;
    if (pick < 40) begin
      rq = REQ_TICK;
      wall_ms += $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0) wall_ms = $urandom;
      nw = wall_ms;
    end else if (pick < 80) begin
      rq = REQ_START;
      if ($urandom_range(0, 19) == 0) nw = $urandom;
    end else if (pick < 93) begin
      rq = REQ_CANCEL;
    end else if (pick < 97) begin
      rq = REQ_UNUSED;
      d  = $urandom;
      iv = $urandom;
      nw = $urandom;
    end else begin
      // tick at an arbitrary time without moving the wall clock
      rq = REQ_TICK;
      nw = $urandom;
    end
    offer_request(rq, ix, md, d, iv, nw);
  endtask

  task automatic test_modes_and_edges();
    logic [TIME_W-1:0] t0;
    t0 = wall_ms;
    offer_request(REQ_START, 3'd0, MODE_ONESHOT, 32'd5, 32'd0, t0);
    tick_at(t0 + 4);
    tick_at(t0 + 5);
    tick_at(t0 + 6);
    offer_request(REQ_START, 3'd1, MODE_REPEAT, 32'd3, 32'd0, t0 + 6);
    // both spans zero: the repeat slot fires on every tick
    offer_request(REQ_START, 3'd2, MODE_REPEAT, 32'd0, 32'd0, t0 + 6);
    offer_request(REQ_START, 3'd3, MODE_COOLDOWN, 32'd10, 32'd2, t0 + 6);
    offer_request(REQ_START, 3'd3, MODE_COOLDOWN, 32'd1, 32'd1, t0 + 6);
    offer_request(REQ_START, 3'd4, MODE_UNUSED, 32'd0, 32'd7, t0 + 6);
    tick_at(t0 + 9);
    tick_at(t0 + 20);
    offer_request(REQ_CANCEL, 3'd1, MODE_REPEAT, '1, '1, '1);
    offer_request(REQ_CANCEL, 3'd2, MODE_ONESHOT, '0, '0, '0);
    offer_request(REQ_UNUSED, '1, '1, '1, '1, '1);
    offer_request(REQ_START, 3'd7, MODE_REPEAT, '1, '1, '1);
    offer_request(REQ_START, 3'd6, MODE_ONESHOT, 32'h8000_0000, 32'd0, t0 + 20);
    offer_request(REQ_START, 3'd5, MODE_ONESHOT, 32'h7FFF_FFFF, 32'd9, t0 + 20);
    tick_at(t0 + 21);
    tick_at(t0 + 20 + 32'h7FFF_FFFF);
    tick_at(t0 + 20 + 32'h8000_0000);
    tick_at(t0 + 20 + 32'h8000_0000);
    offer_request(REQ_CANCEL, 3'd7, MODE_ONESHOT, '0, '0, '0);
    offer_request(REQ_CANCEL, 3'd6, MODE_ONESHOT, '0, '0, '0);
    drain();
    wall_ms = t0 + 100;
  endtask

  task automatic test_scan_count();
    logic [CNT_W-1:0] counts[6];
    counts = '{4'd0, 4'd1, 4'd3, 4'd9, 4'd15, 4'd8};
    for (int k = 0; k < SLOTS; k++) begin
      offer_request(REQ_START, IDX_W'(k), MODE_REPEAT, 32'd0, 32'd0, wall_ms);
    end
    foreach (counts[i]) begin
      drain();
      set_in_use(counts[i]);
      tick_at(wall_ms);
      tick_at(wall_ms + 1);
    end
    drain();
  endtask

  // Hold the output for a long stretch while ticks keep coming, every slot due.
  task automatic test_output_backpressure();
    tx_fast = 1'b1;
    rx_hold = 400;
    for (int i = 0; i < 8; i++) begin
      wall_ms += 1;
      tick_at(wall_ms);
    end
    tx_fast = 1'b0;
    drain();
    for (int k = 0; k < SLOTS; k++) begin
      offer_request(REQ_CANCEL, IDX_W'(k), MODE_ONESHOT, '0, '0, '0);
    end
    drain();
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts[6];
    counts = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd9, 4'd5};
    foreach (counts[ph]) begin
      set_in_use((ph == 5) ? CNT_W'($urandom) : counts[ph]);
      tx_fast = (ph == 2 || ph == 5);
      rx_fast = (ph == 3 || ph == 5);
      if (ph == 2) wall_ms = 32'hFFFF_FFC0;
      for (int i = 0; i < 75; i++) random_request();
      // pause the sender until every fire has come out
      drain();
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // receiver: random stall after each word, plus a long hold when asked
  initial begin
    int left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        if (out_valid && !out_stall) left = pick_gap(rx_fast);
        else if (left > 0) left--;
        out_stall <= (left > 0);
      end
    end
  end

  always @(posedge clk) begin
    fire_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_fires.size() == 0) begin
        flag_error("fire with none pending", '0, TIME_W'(fired_index));
      end else begin
        want = due_fires.pop_front();
        if (fired_index != want.idx)
          flag_error("fired_index", TIME_W'(want.idx), TIME_W'(fired_index));
        if (fired_duration != want.dur) flag_error("fired_duration", want.dur, fired_duration);
        if (last_fire != want.last)
          flag_error("last_fire", TIME_W'(want.last), TIME_W'(last_fire));
      end
    end
  end

  initial begin
    in_valid      = 1'b0;
    req_type      = REQ_TICK;
    slot_sel      = '0;
    arm_mode      = MODE_ONESHOT;
    first_delay   = '0;
    repeat_period = '0;
    now_ms        = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    err_cnt       = 0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    rx_hold       = 0;
    wall_ms       = 32'd1000;
    reset_slots();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_modes_and_edges();
    test_scan_count();
    test_output_backpressure();
    test_random_traffic();

    drain();
    if (err_cnt == 0 && due_fires.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
